[rtl/dcae_pkg.sv]
// Shared types and constants for the daisy-chain address enumerator.
// Holds the classified item, result, mode and register index codes.
// No dependencies.
package dcae_pkg;

    localparam int TIMEOUT_MIN_S   = 1;
    localparam int TIMEOUT_MAX_S   = 60;
    localparam int SERVICE_ADDRESS = 250;
    localparam int MS_PER_S        = 1000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_S   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_RESET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_ASSIGN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_DONE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_HIGH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST   = 3'd7;

    localparam logic [2:0] OP_FRAME = 3'd0;
    localparam logic [2:0] OP_TICK  = 3'd1;
    localparam logic [2:0] OP_ECHO  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_INIT  = 3'd4;

    typedef enum logic [1:0] {
        MODE_UNADDR = 2'd0,
        MODE_ENUM   = 2'd1,
        MODE_ADDR   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_RESET,
        K_ASSIGN,
        K_DONE,
        K_TICK,
        K_ECHO,
        K_CLEAR,
        K_INIT
    } kind_t;

    typedef struct packed {
        logic [7:0] lowest;
        logic [7:0] highest;
    } bounds_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  pay;
        logic        pay_ok;
        logic        prev_active;
        logic [15:0] tick_ms;
        logic [7:0]  frame_address;
        logic        fa_bcast;
        logic [15:0] init_ms;
        logic [7:0]  init_addr;
        logic        init_addr_ok;
    } item_t;

    typedef struct packed {
        logic        responds;
        logic [7:0]  persisted_address;
        logic        ack_request;
        logic        store_write_request;
        logic        error_code;
        logic        next_enable;
        logic        service_mode;
        logic [7:0]  node_address;
        logic [1:0]  mode;
    } result_t;

endpackage

[rtl/daisy_chain_address_enumerator_unit.sv]
// Daisy-chain address enumerator, top level.
// Input beat to result beat: queue write, then back-end result register.
// Throughput: one beat per cycle unless m_tready stalls; state updates on each pop.
// A 2-entry queue decouples decode from execution; output register holds the result.
// Reset: rst_n asynchronous, active low; clears state, queue and config to defaults.
// Depends on dcae_pkg, dcae_front, dcae_queue, dcae_back.
module daisy_chain_address_enumerator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dcae_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // command[7:0], payload_length[15:8], payload_byte[23:16], prev_active[24],
    // tick_ms[40:25], frame_address[48:41], zero fill[55:49]
    input  logic [55:0]                    s_tdata,
    // operation[2:0]
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // mode[1:0], node_address[9:2], service_mode[10], next_enable[11], error_code[12],
    // store_write_request[13], ack_request[14], persisted_address[22:15], responds[23]
    output logic [23:0]                    m_tdata
);

    dcae_pkg::item_t   front_item;
    dcae_pkg::item_t   q_item;
    dcae_pkg::bounds_t bounds;
    dcae_pkg::result_t res;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;

    assign s_tready = !q_full;

    dcae_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (s_tuser),
        .command        (s_tdata[7:0]),
        .payload_length (s_tdata[15:8]),
        .payload_byte   (s_tdata[23:16]),
        .prev_active    (s_tdata[24]),
        .tick_ms        (s_tdata[40:25]),
        .frame_address  (s_tdata[48:41]),
        .item           (front_item),
        .bounds         (bounds)
    );

    dcae_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_data (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_item),
        .empty     (q_empty)
    );

    dcae_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .bounds     (bounds),
        .item       (q_item),
        .item_valid (!q_empty),
        .item_pop   (q_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = res;

endmodule

[rtl/dcae_front.sv]
// Front end: configuration registers, input decode and classification.
// Depends on dcae_pkg.
module dcae_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dcae_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic [2:0]                     operation,
    input  logic [7:0]                     command,
    input  logic [7:0]                     payload_length,
    input  logic [7:0]                     payload_byte,
    input  logic                           prev_active,
    input  logic [15:0]                    tick_ms,
    input  logic [7:0]                     frame_address,
    output dcae_pkg::item_t                item,
    output dcae_pkg::bounds_t              bounds
);

    logic [7:0] stored_addr_reg;
    logic [7:0] timeout_s_reg;
    logic [7:0] cmd_reset_reg;
    logic [7:0] cmd_assign_reg;
    logic [7:0] cmd_done_reg;
    logic [7:0] addr_low_reg;
    logic [7:0] addr_high_reg;
    logic [7:0] broadcast_reg;

    logic [7:0]  secs;
    logic [17:0] ms_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_addr_reg <= 8'd0;
            timeout_s_reg   <= 8'd0;
            cmd_reset_reg   <= 8'd0;
            cmd_assign_reg  <= 8'd1;
            cmd_done_reg    <= 8'd2;
            addr_low_reg    <= 8'd1;
            addr_high_reg   <= 8'd249;
            broadcast_reg   <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcae_pkg::CFG_STORED_ADDR: stored_addr_reg <= cfg_data;
                dcae_pkg::CFG_TIMEOUT_S:   timeout_s_reg   <= cfg_data;
                dcae_pkg::CFG_CMD_RESET:   cmd_reset_reg   <= cfg_data;
                dcae_pkg::CFG_CMD_ASSIGN:  cmd_assign_reg  <= cfg_data;
                dcae_pkg::CFG_CMD_DONE:    cmd_done_reg    <= cfg_data;
                dcae_pkg::CFG_ADDR_LOW:    addr_low_reg    <= cfg_data;
                dcae_pkg::CFG_ADDR_HIGH:   addr_high_reg   <= cfg_data;
                dcae_pkg::CFG_BROADCAST:   broadcast_reg   <= cfg_data;
                default:                   broadcast_reg   <= broadcast_reg;
            endcase
        end
    end

    assign bounds.lowest  = addr_low_reg;
    assign bounds.highest = addr_high_reg;

    always_comb
    begin
        if (timeout_s_reg < 8'(dcae_pkg::TIMEOUT_MIN_S))
            secs = 8'(dcae_pkg::TIMEOUT_MIN_S);
        else if (timeout_s_reg > 8'(dcae_pkg::TIMEOUT_MAX_S))
            secs = 8'(dcae_pkg::TIMEOUT_MAX_S);
        else
            secs = timeout_s_reg;
        ms_full = 18'(secs) * 18'(dcae_pkg::MS_PER_S);
    end

    always_comb
    begin
        case (operation)
            dcae_pkg::OP_FRAME:
            begin
                if (command == cmd_reset_reg)
                    item.kind = dcae_pkg::K_RESET;
                else if (command == cmd_assign_reg)
                    item.kind = dcae_pkg::K_ASSIGN;
                else if (command == cmd_done_reg)
                    item.kind = dcae_pkg::K_DONE;
                else
                    item.kind = dcae_pkg::K_NOP;
            end
            dcae_pkg::OP_TICK:  item.kind = dcae_pkg::K_TICK;
            dcae_pkg::OP_ECHO:  item.kind = dcae_pkg::K_ECHO;
            dcae_pkg::OP_CLEAR: item.kind = dcae_pkg::K_CLEAR;
            dcae_pkg::OP_INIT:  item.kind = dcae_pkg::K_INIT;
            default:            item.kind = dcae_pkg::K_NOP;
        endcase
        item.pay           = payload_byte;
        item.pay_ok        = (payload_length == 8'd1) && (payload_byte >= addr_low_reg)
                             && (payload_byte <= addr_high_reg);
        item.prev_active   = prev_active;
        item.tick_ms       = tick_ms;
        item.frame_address = frame_address;
        item.fa_bcast      = (frame_address == broadcast_reg);
        item.init_ms       = ms_full[15:0];
        item.init_addr     = stored_addr_reg;
        item.init_addr_ok  = (stored_addr_reg >= addr_low_reg)
                             && (stored_addr_reg <= addr_high_reg);
    end

endmodule

[rtl/dcae_queue.sv]
// Short FIFO of classified beats between front and back end.
// Depends on dcae_pkg.
module dcae_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dcae_pkg::item_t push_data,
    output logic            full,
    input  logic            pop,
    output dcae_pkg::item_t pop_data,
    output logic            empty
);

    dcae_pkg::item_t mem [dcae_pkg::QUEUE_DEPTH];

    logic [dcae_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dcae_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dcae_pkg::QCNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full     = (count_reg == dcae_pkg::QCNT_W'(dcae_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == dcae_pkg::QPTR_W'(dcae_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + dcae_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == dcae_pkg::QPTR_W'(dcae_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + dcae_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + dcae_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - dcae_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/dcae_back.sv]
// Back end: enumeration state, item execution and registered result beat.
// Depends on dcae_pkg.
module dcae_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dcae_pkg::bounds_t bounds,
    input  dcae_pkg::item_t   item,
    input  logic              item_valid,
    output logic              item_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output dcae_pkg::result_t res
);

    dcae_pkg::mode_t mode_reg, mode_next;
    logic [7:0]  address_reg, address_next;
    logic [7:0]  persist_reg, persist_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] timeout_ms_reg, timeout_ms_next;
    logic        next_en_reg, next_en_next;
    logic        service_reg, service_next;
    logic        collision_reg, collision_next;
    logic        write_req_reg, write_req_next;
    logic        ack_req_reg, ack_req_next;

    logic              valid_reg;
    dcae_pkg::result_t res_reg, res_next;

    logic [16:0] tick_sum;
    logic        persist_ok;

    assign item_pop  = item_valid && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res       = res_reg;

    assign tick_sum   = {1'b0, elapsed_reg} + {1'b0, item.tick_ms};
    assign persist_ok = (persist_reg >= bounds.lowest) && (persist_reg <= bounds.highest);

    // next state
    always_comb
    begin
        mode_next       = mode_reg;
        address_next    = address_reg;
        persist_next    = persist_reg;
        elapsed_next    = elapsed_reg;
        timeout_ms_next = timeout_ms_reg;
        next_en_next    = next_en_reg;
        service_next    = service_reg;
        collision_next  = collision_reg;
        write_req_next  = write_req_reg;
        ack_req_next    = ack_req_reg;
        case (item.kind)
            dcae_pkg::K_RESET:
            begin
                mode_next      = dcae_pkg::MODE_ENUM;
                address_next   = 8'd0;
                service_next   = 1'b0;
                next_en_next   = 1'b0;
                elapsed_next   = 16'd0;
            end
            dcae_pkg::K_ASSIGN:
            begin
                if (item.pay_ok && (mode_reg == dcae_pkg::MODE_ENUM) && item.prev_active
                    && !next_en_reg)
                begin
                    address_next   = item.pay;
                    service_next   = 1'b0;
                    persist_next   = item.pay;
                    write_req_next = 1'b1;
                    next_en_next   = 1'b1;
                    ack_req_next   = 1'b1;
                    mode_next      = dcae_pkg::MODE_ADDR;
                    collision_next = 1'b0;
                end
            end
            dcae_pkg::K_DONE, dcae_pkg::K_TICK:
            begin
                if (mode_reg == dcae_pkg::MODE_ENUM)
                begin
                    if ((item.kind == dcae_pkg::K_DONE)
                        || (tick_sum >= {1'b0, timeout_ms_reg}))
                    begin
                        // fall back to stored or service address
                        address_next = persist_ok ? persist_reg
                                                  : 8'(dcae_pkg::SERVICE_ADDRESS);
                        service_next = !persist_ok;
                        mode_next    = dcae_pkg::MODE_ADDR;
                        elapsed_next = 16'd0;
                    end
                    else
                        elapsed_next = tick_sum[15:0];
                end
            end
            dcae_pkg::K_ECHO:
            begin
                if (mode_reg == dcae_pkg::MODE_ADDR)
                begin
                    address_next   = 8'd0;
                    service_next   = 1'b0;
                    next_en_next   = 1'b0;
                    collision_next = 1'b1;
                    mode_next      = dcae_pkg::MODE_UNADDR;
                end
            end
            dcae_pkg::K_CLEAR:
            begin
                write_req_next = 1'b0;
                ack_req_next   = 1'b0;
            end
            dcae_pkg::K_INIT:
            begin
                persist_next    = item.init_addr;
                timeout_ms_next = item.init_ms;
                elapsed_next    = 16'd0;
                next_en_next    = 1'b0;
                collision_next  = 1'b0;
                write_req_next  = 1'b0;
                ack_req_next    = 1'b0;
                service_next    = 1'b0;
                mode_next       = item.init_addr_ok ? dcae_pkg::MODE_ADDR
                                                    : dcae_pkg::MODE_UNADDR;
                address_next    = item.init_addr_ok ? item.init_addr : 8'd0;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // result fields
    always_comb
    begin
        res_next.mode                = mode_next;
        res_next.node_address        = (mode_next == dcae_pkg::MODE_ADDR) ? address_next : 8'd0;
        res_next.service_mode        = service_next;
        res_next.next_enable         = next_en_next;
        res_next.error_code          = collision_next;
        res_next.store_write_request = write_req_next;
        res_next.ack_request         = ack_req_next;
        res_next.persisted_address   = persist_next;
        res_next.responds            = item.fa_bcast || ((mode_reg == dcae_pkg::MODE_ADDR)
                                       && (item.frame_address == address_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= dcae_pkg::MODE_UNADDR;
            address_reg    <= 8'd0;
            persist_reg    <= 8'd0;
            elapsed_reg    <= 16'd0;
            timeout_ms_reg <= 16'd0;
            next_en_reg    <= 1'b0;
            service_reg    <= 1'b0;
            collision_reg  <= 1'b0;
            write_req_reg  <= 1'b0;
            ack_req_reg    <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                mode_reg       <= mode_next;
                address_reg    <= address_next;
                persist_reg    <= persist_next;
                elapsed_reg    <= elapsed_next;
                timeout_ms_reg <= timeout_ms_next;
                next_en_reg    <= next_en_next;
                service_reg    <= service_next;
                collision_reg  <= collision_next;
                write_req_reg  <= write_req_next;
                ack_req_reg    <= ack_req_next;
                valid_reg      <= 1'b1;
            end
            else if (res_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
            res_reg <= res_next;
    end

endmodule
